// ===== hw/rtl/serial_request_buffer_defines.svh =====
// Assertion macros used by the serial request buffer RTL.
`ifndef SERIAL_REQUEST_BUFFER_DEFINES_SVH
`define SERIAL_REQUEST_BUFFER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SRB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srb assertion failed");

// next-cycle implication, disabled while in reset
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srb assertion failed");

`endif

// ===== hw/rtl/srb_pkg.sv =====
// Types and codes of the serial request buffer.
package srb_pkg;

  localparam logic [2:0] MODE_RX    = 3'd0;
  localparam logic [2:0] MODE_TXRDY = 3'd1;
  localparam logic [2:0] MODE_READ  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_OPEN  = 3'd4;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_TX    = 2'd1;
  localparam logic [1:0] KIND_DELIV = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_NOPORT  = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  port;
    logic [7:0]  data_byte;
    logic [15:0] request_count;
    logic        nonblocking;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  port_out;
    logic [7:0]  byte_out;
    logic        finished;
    logic [1:0]  status;
    logic [15:0] remaining;
    logic        last;
  } out_t;

  // classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_UNDEF,
    OP_BAD_REQ,
    OP_BAD_OPEN,
    OP_BAD_EVT,
    OP_RX,
    OP_TXRDY,
    OP_READ,
    OP_WRITE,
    OP_OPEN
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  port;
    logic [1:0]  pidx;
    logic [7:0]  data_byte;
    logic [15:0] count;
    logic        nb;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/serial_request_buffer.sv =====
// Top level of the serial request buffer: front, command queue and back.
// Path: front register, command queue, back end fetch (S_IDLE) and execute (S_EXEC), and
// result register; a read that takes ring bytes also passes the ring store read register.
// The back end works on one command at a time; a read does one ring store read per byte.
// Reset (rst_n low, synchronous) empties both queues and zeroes pointers and request state.
// Ring store contents are not cleared; only written entries are ever read back.
`include "serial_request_buffer_defines.svh"

module serial_request_buffer import srb_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int PORT_COUNT  = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_item,
  output logic empty,
  input  logic pop,
  output out_t out_item
);

  // front -> queue
  logic    cmd_push;
  cmd_t    cmd_data;
  // queue -> back
  logic    cmd_pop;
  cmd_t    cmd_head;
  q_stat_t q_stat;

  // classifies each input beat (bad port, undefined mode) into a command
  srb_front #(
    .PORT_COUNT (PORT_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .q_stat   (q_stat),
    .cmd_push (cmd_push),
    .cmd_data (cmd_data)
  );

  // short queue so the front keeps taking beats while a read drains
  srb_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_push (cmd_push),
    .cmd_data (cmd_data),
    .cmd_pop  (cmd_pop),
    .cmd_head (cmd_head),
    .q_stat   (q_stat)
  );

  // carries out commands against the rings and per-port request state;
  // its result register parts it from the consumer
  srb_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PORT_COUNT  (PORT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_head (cmd_head),
    .q_stat   (q_stat),
    .cmd_pop  (cmd_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  // queue must never be written while full
  `SRB_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, cmd_push, !q_stat.full)
  // a pop without a push always frees a slot
  `SRB_ASSERT_NEXT(a_pop_frees, clk, rst_n, cmd_pop && !cmd_push, !q_stat.full)
  // a busy rejection always ends the request in a single beat
  `SRB_ASSERT_IMPLIES(a_busy_form, clk, rst_n, !empty && out_item.status == ST_BUSY, out_item.kind == KIND_END && out_item.finished && out_item.last)
  // a result of kind none never completes a request and is always the last beat
  `SRB_ASSERT_IMPLIES(a_none_unfinished, clk, rst_n, !empty && out_item.kind == KIND_NONE, !out_item.finished && out_item.last)

endmodule

// ===== hw/rtl/srb_front.sv =====
// Front end: takes input beats and classifies them into commands.
module srb_front import srb_pkg::*; #(
  parameter int PORT_COUNT = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  in_t     in_item,
  output logic    full,
  input  q_stat_t q_stat,
  output logic    cmd_push,
  output cmd_t    cmd_data
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r;
  cmd_t cls;
  logic accept;
  logic bad;

  assign cmd_push  = valid_r && !q_stat.full;
  assign full      = valid_r && q_stat.full;
  assign accept    = push && !full;
  assign valid_nxt = accept || (valid_r && !cmd_push);
  assign cmd_data  = cmd_r;
  assign bad       = {1'b0, in_item.port} >= 3'(PORT_COUNT);

  always_comb begin
    cls.port      = in_item.port;
    cls.pidx      = bad ? 2'd0 : in_item.port;
    cls.data_byte = in_item.data_byte;
    cls.count     = in_item.request_count;
    cls.nb        = in_item.nonblocking;
    cls.op        = OP_UNDEF;
    if (in_item.mode > MODE_OPEN) begin
      cls.op = OP_UNDEF;
    end else if (bad) begin
      if (in_item.mode == MODE_READ || in_item.mode == MODE_WRITE) begin
        cls.op = OP_BAD_REQ;
      end else if (in_item.mode == MODE_OPEN) begin
        cls.op = OP_BAD_OPEN;
      end else begin
        cls.op = OP_BAD_EVT;
      end
    end else begin
      case (in_item.mode)
        MODE_RX:    cls.op = OP_RX;
        MODE_TXRDY: cls.op = OP_TXRDY;
        MODE_READ:  cls.op = OP_READ;
        MODE_WRITE: cls.op = OP_WRITE;
        MODE_OPEN:  cls.op = OP_OPEN;
        default:    cls.op = OP_UNDEF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cls;
    end
  end

endmodule

// ===== hw/rtl/srb_cmd_q.sv =====
// Two-entry command queue between front and back.
module srb_cmd_q import srb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_push,
  input  cmd_t    cmd_data,
  input  logic    cmd_pop,
  output cmd_t    cmd_head,
  output q_stat_t q_stat
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign cmd_head     = slot_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;

  always_comb begin
    wr_ptr_nxt = cmd_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(cmd_push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_push) begin
      slot_r[wr_ptr_r] <= cmd_data;
    end
  end

endmodule

// ===== hw/rtl/srb_back.sv =====
// Back end: per-port ring store, request state and result register.
module srb_back import srb_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int PORT_COUNT  = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd_head,
  input  q_stat_t q_stat,
  output logic    cmd_pop,
  input  logic    pop,
  output logic    empty,
  output out_t    out_item
);

  localparam int QW        = $clog2(QUEUE_DEPTH);
  localparam int PIW       = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int MEM_DEPTH = PORT_COUNT * QUEUE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_RDATA = 3'b100
  } bk_state_t;

  bk_state_t   state_r, state_nxt;
  cmd_t        cur_r, cur_nxt;
  logic [QW-1:0] head_r [PORT_COUNT], head_nxt [PORT_COUNT];
  logic [QW-1:0] tail_r [PORT_COUNT], tail_nxt [PORT_COUNT];
  logic        rbusy_r [PORT_COUNT], rbusy_nxt [PORT_COUNT];
  logic [15:0] rleft_r [PORT_COUNT], rleft_nxt [PORT_COUNT];
  logic        wbusy_r [PORT_COUNT], wbusy_nxt [PORT_COUNT];
  logic [15:0] wleft_r [PORT_COUNT], wleft_nxt [PORT_COUNT];
  logic        out_valid_r, out_valid_nxt;
  out_t        out_item_r, out_item_nxt;
  // byte in flight from the ring store
  logic [15:0] dr_left_r, dr_left_nxt;
  logic        dr_last_r, dr_last_nxt;
  logic        dr_fin_r, dr_fin_nxt;
  logic [1:0]  dr_stat_r, dr_stat_nxt;

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  rd_data_r;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;

  logic [PIW-1:0] p;
  logic        out_ready;
  logic        ring_empty;
  logic [QW-1:0] head_inc, tail_inc;
  logic [15:0] rleft_m1, wleft_m1, cnt_m1;
  logic [15:0] iss_left, iss_left_m1;
  logic        iss_last;
  logic        emit;
  out_t        res;

  function automatic logic [QW-1:0] next_pos(input logic [QW-1:0] v);
    return (v == QW'(QUEUE_DEPTH - 1)) ? '0 : v + QW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [PIW-1:0] pi,
                                            input logic [QW-1:0] ptr);
    return AW'(AW'(pi) * AW'(QUEUE_DEPTH)) + AW'(ptr);
  endfunction

  assign p           = cur_r.pidx[PIW-1:0];
  assign out_ready   = !out_valid_r || pop;
  assign ring_empty  = tail_r[p] == head_r[p];
  assign head_inc    = next_pos(head_r[p]);
  assign tail_inc    = next_pos(tail_r[p]);
  assign rleft_m1    = rleft_r[p] - 16'd1;
  assign wleft_m1    = wleft_r[p] - 16'd1;
  assign cnt_m1      = cur_r.count - 16'd1;
  assign iss_left    = (state_r == S_EXEC) ? cur_r.count : dr_left_r;
  assign iss_left_m1 = iss_left - 16'd1;
  assign iss_last    = (iss_left_m1 == 16'd0) || (tail_inc == head_r[p]);
  assign empty       = !out_valid_r;
  assign out_item    = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    rbusy_nxt     = rbusy_r;
    rleft_nxt     = rleft_r;
    wbusy_nxt     = wbusy_r;
    wleft_nxt     = wleft_r;
    dr_left_nxt   = dr_left_r;
    dr_last_nxt   = dr_last_r;
    dr_fin_nxt    = dr_fin_r;
    dr_stat_nxt   = dr_stat_r;
    out_valid_nxt = out_valid_r && !pop;
    out_item_nxt  = out_item_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = addr_of(p, head_r[p]);
    mem_ra        = addr_of(p, tail_r[p]);
    emit          = 1'b0;

    res.kind      = KIND_NONE;
    res.port_out  = cur_r.port;
    res.byte_out  = 8'd0;
    res.finished  = 1'b0;
    res.status    = ST_OK;
    res.remaining = 16'd0;
    res.last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          cmd_pop   = 1'b1;
          cur_nxt   = cmd_head;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cur_r.op == OP_READ && !rbusy_r[p] && cur_r.count != 16'd0 && !ring_empty) begin
          // first ring byte of a read; the result goes out with the data
          mem_re      = 1'b1;
          tail_nxt[p] = tail_inc;
          state_nxt   = S_RDATA;
        end else if (out_ready) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          case (cur_r.op)
            OP_BAD_REQ: begin
              res.kind      = KIND_END;
              res.finished  = 1'b1;
              res.status    = ST_NOPORT;
              res.remaining = cur_r.count;
            end
            OP_BAD_OPEN: begin
              res.kind   = KIND_END;
              res.status = ST_NOPORT;
            end
            OP_BAD_EVT: begin
              res.status = ST_NOPORT;
            end
            OP_RX: begin
              if (rbusy_r[p]) begin
                rleft_nxt[p]  = rleft_m1;
                rbusy_nxt[p]  = rleft_m1 != 16'd0;
                res.kind      = KIND_DELIV;
                res.byte_out  = cur_r.data_byte;
                res.finished  = rleft_m1 == 16'd0;
                res.remaining = rleft_m1;
              end else begin
                // ring push; full ring drops its oldest byte
                mem_we      = 1'b1;
                head_nxt[p] = head_inc;
                if (head_inc == tail_r[p]) begin
                  tail_nxt[p] = tail_inc;
                end
              end
            end
            OP_TXRDY: begin
              if (wbusy_r[p]) begin
                wleft_nxt[p]  = wleft_m1;
                wbusy_nxt[p]  = wleft_m1 != 16'd0;
                res.kind      = KIND_TX;
                res.byte_out  = cur_r.data_byte;
                res.finished  = wleft_m1 == 16'd0;
                res.remaining = wleft_m1;
              end
            end
            OP_READ: begin
              if (rbusy_r[p]) begin
                res.kind      = KIND_END;
                res.finished  = 1'b1;
                res.status    = ST_BUSY;
                res.remaining = cur_r.count;
              end else if (cur_r.count == 16'd0) begin
                res.kind     = KIND_END;
                res.finished = 1'b1;
              end else if (cur_r.nb) begin
                res.kind      = KIND_END;
                res.finished  = 1'b1;
                res.status    = ST_TIMEOUT;
                res.remaining = cur_r.count;
              end else begin
                rbusy_nxt[p]  = 1'b1;
                rleft_nxt[p]  = cur_r.count;
                res.remaining = cur_r.count;
              end
            end
            OP_WRITE: begin
              if (wbusy_r[p]) begin
                res.kind      = KIND_END;
                res.finished  = 1'b1;
                res.status    = ST_BUSY;
                res.remaining = cur_r.count;
              end else if (cur_r.count == 16'd0) begin
                res.kind     = KIND_END;
                res.finished = 1'b1;
              end else begin
                wbusy_nxt[p]  = cnt_m1 != 16'd0;
                wleft_nxt[p]  = cnt_m1;
                res.kind      = KIND_TX;
                res.byte_out  = cur_r.data_byte;
                res.finished  = cnt_m1 == 16'd0;
                res.remaining = cnt_m1;
              end
            end
            OP_OPEN: begin
              head_nxt[p]  = '0;
              tail_nxt[p]  = '0;
              rbusy_nxt[p] = 1'b0;
              rleft_nxt[p] = 16'd0;
              wbusy_nxt[p] = 1'b0;
              wleft_nxt[p] = 16'd0;
              res.kind     = KIND_END;
            end
            default: begin
              res.kind = KIND_NONE;
            end
          endcase
        end
      end

      S_RDATA: begin
        if (out_ready) begin
          emit          = 1'b1;
          res.kind      = KIND_DELIV;
          res.byte_out  = rd_data_r;
          res.finished  = dr_last_r && dr_fin_r;
          res.status    = dr_last_r ? dr_stat_r : ST_OK;
          res.remaining = dr_left_r;
          res.last      = dr_last_r;
          if (dr_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re      = 1'b1;
            tail_nxt[p] = tail_inc;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // bookkeeping for each ring byte fetched
    if (mem_re) begin
      dr_left_nxt = iss_left_m1;
      dr_last_nxt = iss_last;
      dr_fin_nxt  = (iss_left_m1 == 16'd0) || cur_r.nb;
      dr_stat_nxt = (iss_left_m1 != 16'd0 && cur_r.nb) ? ST_TIMEOUT : ST_OK;
      if (iss_last && iss_left_m1 != 16'd0 && !cur_r.nb) begin
        rbusy_nxt[p] = 1'b1;
        rleft_nxt[p] = iss_left_m1;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        rbusy_r[i] <= 1'b0;
        rleft_r[i] <= 16'd0;
        wbusy_r[i] <= 1'b0;
        wleft_r[i] <= 16'd0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      rbusy_r     <= rbusy_nxt;
      rleft_r     <= rleft_nxt;
      wbusy_r     <= wbusy_nxt;
      wleft_r     <= wleft_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
    dr_left_r  <= dr_left_nxt;
    dr_last_r  <= dr_last_nxt;
    dr_fin_r   <= dr_fin_nxt;
    dr_stat_r  <= dr_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= cur_r.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

endmodule
